/* hw/rtl/hpr_pkg.sv */
// Shared constants and types for the handshake pad report sender.
package hpr_pkg;

    // Fixed frame bytes: first byte is {ID_FIRST, REPORT_LEN}, last byte is ID_FIRST
    localparam logic [3:0] ID_FIRST    = 4'h1;
    localparam logic [3:0] REPORT_LEN  = 4'h6;
    localparam int         NIBBLE_COUNT = 16;
    localparam int         NIB_IDX_W    = $clog2(NIBBLE_COUNT);

    // Transfer phase, one-hot
    typedef enum logic [3:0] {
        PH_WAIT_SELECT  = 4'b0001,
        PH_WAIT_REQUEST = 4'b0010,
        PH_SENDING      = 4'b0100,
        PH_WAIT_RELEASE = 4'b1000
    } phase_t;

    // Control shared by every nibble cell
    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

endpackage

/* hw/rtl/handshake_pad_report_sender.sv */
// Top level of the handshake pad report sender.
//
// Device side of a three-wire nibble handshake for a game pad. Each request
// on the input channel carries one clock sample of the select line (th_line),
// the host request line (tr_line) and the current pad report. Each accepted
// request yields exactly one request on the output channel: the data nibble
// and TL acknowledge levels driven after that sample.
// The result is registered and shows on the output in the cycle after the
// input request is accepted. Throughput: one request per cycle while results
// are taken; the next input is taken in the same cycle as the pending result.
// On select low, while waiting for select, the report is loaded into a chain
// of sixteen nibble cells; every nibble sent shifts the chain by one cell, so
// the head cell always holds the next nibble of the frame.
// Reset: the block waits for select low and drives nibble 1 with TL high;
// the output channel holds no result.
// When the receiver stalls, the result holds on the output and in_ready
// drops until it is taken; no request is lost or repeated.
module handshake_pad_report_sender (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        th_line,
    input  logic        tr_line,
    input  logic [15:0] buttons,
    input  logic [7:0]  stick_x,
    input  logic [7:0]  stick_y,
    input  logic [7:0]  right_trigger,
    input  logic [7:0]  left_trigger,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  data_nibble,
    output logic        ack_line
);

    localparam int N = hpr_pkg::NIBBLE_COUNT;

    hpr_pkg::phase_t              phase_reg, phase_next;
    logic [hpr_pkg::NIB_IDX_W-1:0] nib_idx_reg, nib_idx_next;
    logic [3:0]                   data_drive_reg, data_drive_next;
    logic                         ack_drive_reg, ack_drive_next;
    logic                         out_valid_reg, out_valid_next;
    logic                         accept;
    hpr_pkg::cell_ctrl_t          ctrl;
    logic [8*N/2-1:0]             frame;
    logic [3:0]                   cell_nibble [N];

    // Take a new request unless a result still waits
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // Frame as sent, byte 0 first
    assign frame = {4'h0, hpr_pkg::ID_FIRST, left_trigger, right_trigger,
                    stick_y, stick_x, buttons, hpr_pkg::ID_FIRST,
                    hpr_pkg::REPORT_LEN};

    // Chain of nibble cells, high nibble of each byte first
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        logic [3:0] neighbor;
        if (i == N - 1)
        begin : g_tail
            assign neighbor = 4'h0;
        end
        else
        begin : g_link
            assign neighbor = cell_nibble[i + 1];
        end
        hpr_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .load_nibble (frame[8*(i/2) + 4*(1 - (i%2)) +: 4]),
            .next_nibble (neighbor),
            .nibble      (cell_nibble[i])
        );
    end

    // Advance the phase and drive levels for one sample
    always_comb
    begin
        phase_next      = phase_reg;
        nib_idx_next    = nib_idx_reg;
        data_drive_next = data_drive_reg;
        ack_drive_next  = ack_drive_reg;
        ctrl            = '0;
        if (accept)
        begin
            unique case (phase_reg)
                hpr_pkg::PH_WAIT_SELECT:
                begin
                    if (!th_line)
                    begin
                        ctrl.load  = 1'b1;
                        phase_next = hpr_pkg::PH_WAIT_REQUEST;
                    end
                end
                hpr_pkg::PH_WAIT_REQUEST:
                begin
                    if (tr_line)
                    begin
                        nib_idx_next = '0;
                        phase_next   = hpr_pkg::PH_SENDING;
                    end
                end
                hpr_pkg::PH_SENDING:
                begin
                    // High nibble on TR low, low nibble on TR high
                    if (tr_line == nib_idx_reg[0])
                    begin
                        data_drive_next = cell_nibble[0];
                        ack_drive_next  = nib_idx_reg[0];
                        nib_idx_next    = nib_idx_reg + 1'b1;
                        ctrl.shift      = 1'b1;
                        if (nib_idx_reg == hpr_pkg::NIB_IDX_W'(N - 1))
                        begin
                            phase_next = hpr_pkg::PH_WAIT_RELEASE;
                        end
                    end
                end
                hpr_pkg::PH_WAIT_RELEASE:
                begin
                    if (th_line)
                    begin
                        phase_next = hpr_pkg::PH_WAIT_SELECT;
                    end
                end
                default:
                begin
                    phase_next = hpr_pkg::PH_WAIT_SELECT;
                end
            endcase
        end
    end

    // Raise the result on accept, drop it when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= hpr_pkg::PH_WAIT_SELECT;
            nib_idx_reg    <= '0;
            data_drive_reg <= hpr_pkg::ID_FIRST;
            ack_drive_reg  <= 1'b1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            nib_idx_reg    <= nib_idx_next;
            data_drive_reg <= data_drive_next;
            ack_drive_reg  <= ack_drive_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign data_nibble = data_drive_reg;
    assign ack_line    = ack_drive_reg;

endmodule

/* hw/rtl/hpr_cell.sv */
// One nibble cell of the frame shift chain.
module hpr_cell (
    input  logic              clk,
    input  hpr_pkg::cell_ctrl_t ctrl,
    input  logic [3:0]        load_nibble,
    input  logic [3:0]        next_nibble,
    output logic [3:0]        nibble
);

    logic [3:0] nibble_reg;
    logic [3:0] nibble_next;

    // Load from the snapshot, advance from the neighbor, or hold
    always_comb
    begin
        nibble_next = nibble_reg;
        if (ctrl.load)
        begin
            nibble_next = load_nibble;
        end
        else if (ctrl.shift)
        begin
            nibble_next = next_nibble;
        end
    end

    always_ff @(posedge clk)
    begin
        nibble_reg <= nibble_next;
    end

    assign nibble = nibble_reg;

endmodule

/* hw/rtl/hpr_checker.sv */
// Port-level checks for the handshake pad report sender, bound to the top level.
module hpr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [3:0]  data_nibble,
    input logic        ack_line
);

    // Every accepted request yields a result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("no result after accepted request");

    // A waiting result blocks the input side
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while result stalled");

    // Drive levels change only after an accepted request
    a_drive_needs_request: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(ack_line) || !$stable(data_nibble) |-> $past(in_valid && in_ready))
        else $error("drive changed without a request");

    // A stalled result holds its payload
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(data_nibble) && $stable(ack_line))
        else $error("stalled result changed");

endmodule

bind handshake_pad_report_sender hpr_checker u_hpr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .data_nibble (data_nibble),
    .ack_line    (ack_line)
);
